FILE: rtl/core/per_peer_failure_rate_limiter_assert.svh
// Assertion macros for the per-peer failure rate limiter.
`ifndef PER_PEER_FAILURE_RATE_LIMITER_ASSERT_SVH
`define PER_PEER_FAILURE_RATE_LIMITER_ASSERT_SVH

// Check that an antecedent implies a consequent in the next cycle.
`define PPFRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check that a condition holds at every clock edge outside reset.
`define PPFRL_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

FILE: rtl/core/pfrl_pkg.sv
// ----------------------------------------------------------------------------
// pfrl_pkg
// Types and constants shared by the per-peer failure rate limiter.
// ----------------------------------------------------------------------------
package pfrl_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int FAILS_DEF   = 16;

    localparam logic [4:0]  FAIL_LIMIT_RST = 5'd10;
    localparam logic [31:0] WINDOW_RST     = 32'd60000;
    localparam logic [31:0] PROTECT_RST    = 32'd600000;

    localparam logic [1:0] OP_FAIL  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_TABLE_FULL = 2'd1;
    localparam logic [1:0] ST_FIFO_FULL  = 2'd2;

    localparam logic [1:0] REG_FAIL_LIMIT = 2'd0;
    localparam logic [1:0] REG_WINDOW     = 2'd1;
    localparam logic [1:0] REG_PROTECT    = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] peer_key;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic       denied;
        logic [4:0] fail_count;
        logic [1:0] status;
    } t_out_item;

    // Deadline t is reached when now - t, taken modulo 2^32, is below 2^31.
    function automatic logic time_reached(logic [31:0] now, logic [31:0] t);
        logic [31:0] d;
        d = now - t;
        return ~d[31];
    endfunction

endpackage

FILE: rtl/core/per_peer_failure_rate_limiter.sv
// ----------------------------------------------------------------------------
// per_peer_failure_rate_limiter
// Flow: a sweep over all ENTRIES slots, popping each slot's expired failures
// from its head and dropping stale slots, then a lookup over all slots and an
// action step, after which the result is held until it is taken.
// One item at a time: a new item is accepted only after the result is taken.
// Reset: synchronous active low, clears slot state and registers to defaults.
// ----------------------------------------------------------------------------
module per_peer_failure_rate_limiter #(
    parameter int ENTRIES         = pfrl_pkg::ENTRIES_DEF,
    parameter int FAILS_PER_ENTRY = pfrl_pkg::FAILS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  pfrl_pkg::t_in_item i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output pfrl_pkg::t_out_item o_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    `include "per_peer_failure_rate_limiter_assert.svh"

    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FW = (FAILS_PER_ENTRY > 1) ? $clog2(FAILS_PER_ENTRY) : 1;
    localparam int CW = $clog2(FAILS_PER_ENTRY + 1);
    localparam int MD = ENTRIES * FAILS_PER_ENTRY;
    localparam int AW = (MD > 1) ? $clog2(MD) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_SLOT, S_READ, S_CHECK, S_LOOK, S_ACT, S_OUT
    } t_state;

    t_state r_state;
    logic [4:0]  r_limit;
    logic [31:0] r_window, r_protect;

    // Per-slot state in flip-flops; slot arrays are small and read at the
    // sweep index or the chosen slot only.
    logic          r_valid  [ENTRIES];
    logic [31:0]   r_key    [ENTRIES];
    logic [CW-1:0] r_count  [ENTRIES];
    logic          r_den    [ENTRIES];
    logic [31:0]   r_dend   [ENTRIES];
    logic [FW-1:0] r_head   [ENTRIES];

    pfrl_pkg::t_in_item  r_in;
    pfrl_pkg::t_out_item r_out;
    logic [EW-1:0] r_idx;
    logic          r_hit, r_free_ok;
    logic [EW-1:0] r_hit_idx, r_free_idx;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0]   mem_wdata, mem_rdata;

    pfrl_expiry_mem #(.DEPTH(MD)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_data      = r_out;

    // Expiry address of a slot's FIFO position.
    function automatic logic [AW-1:0] faddr(logic [EW-1:0] e, logic [FW-1:0] p);
        return AW'(AW'(e) * AW'(FAILS_PER_ENTRY) + AW'(p));
    endfunction

    logic [EW-1:0] act_e;
    logic          act_ok;
    logic [FW-1:0] tail;
    logic [CW:0]   tail_sum;
    logic [CW-1:0] n_cnt;

    always_comb begin
        act_e  = r_hit ? r_hit_idx : r_free_idx;
        act_ok = r_hit || r_free_ok;
        // Count of the chosen slot once the new failure is held.
        n_cnt  = r_hit ? CW'(r_count[act_e] + 1'b1) : CW'(1);
        tail_sum = (CW+1)'(r_head[act_e]) + (CW+1)'(r_count[act_e]);
        if (tail_sum >= (CW+1)'(FAILS_PER_ENTRY)) begin
            tail = FW'(tail_sum - (CW+1)'(FAILS_PER_ENTRY));
        end else begin
            tail = FW'(tail_sum);
        end
        mem_raddr = faddr(r_idx, r_head[r_idx]);
        mem_we    = (r_state == S_ACT) && (r_in.op == pfrl_pkg::OP_FAIL) && act_ok &&
                    (r_count[act_e] < CW'(FAILS_PER_ENTRY));
        mem_waddr = faddr(act_e, tail);
        mem_wdata = r_in.now_ms + r_window;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_limit   <= pfrl_pkg::FAIL_LIMIT_RST;
            r_window  <= pfrl_pkg::WINDOW_RST;
            r_protect <= pfrl_pkg::PROTECT_RST;
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
                r_count[i] <= '0;
                r_den[i]   <= 1'b0;
                r_head[i]  <= '0;
            end
            r_idx     <= '0;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        unique case (i_cfg_index)
                            pfrl_pkg::REG_FAIL_LIMIT: r_limit   <= i_cfg_data[4:0];
                            pfrl_pkg::REG_WINDOW:     r_window  <= i_cfg_data;
                            pfrl_pkg::REG_PROTECT:    r_protect <= i_cfg_data;
                            default: ;
                        endcase
                    end
                    if (i_valid) begin
                        r_in      <= i_data;
                        r_idx     <= '0;
                        r_hit     <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_state   <= S_SLOT;
                    end
                end
                S_SLOT: begin
                    // Read the head if there is one, else settle the slot.
                    if (r_valid[r_idx] && r_count[r_idx] != '0) begin
                        r_state <= S_READ;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_READ: begin
                    if (pfrl_pkg::time_reached(r_in.now_ms, mem_rdata)) begin
                        r_head[r_idx]  <= (r_head[r_idx] == FW'(FAILS_PER_ENTRY - 1)) ?
                                          '0 : FW'(r_head[r_idx] + 1'b1);
                        r_count[r_idx] <= r_count[r_idx] - 1'b1;
                        r_state        <= S_SLOT;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_valid[r_idx] &&
                        ((r_den[r_idx] &&
                          pfrl_pkg::time_reached(r_in.now_ms, r_dend[r_idx])) ||
                         (r_count[r_idx] == '0 && !r_den[r_idx]))) begin
                        // Drop the slot.
                        r_valid[r_idx] <= 1'b0;
                        r_count[r_idx] <= '0;
                        r_den[r_idx]   <= 1'b0;
                        r_head[r_idx]  <= '0;
                    end
                    if (r_idx == EW'(ENTRIES - 1)) begin
                        r_idx   <= '0;
                        r_state <= S_LOOK;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SLOT;
                    end
                end
                S_LOOK: begin
                    // One slot per cycle: match and lowest free.
                    if (r_valid[r_idx] && r_key[r_idx] == r_in.peer_key && !r_hit) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_idx;
                    end
                    if (!r_valid[r_idx] && !r_free_ok) begin
                        r_free_ok  <= 1'b1;
                        r_free_idx <= r_idx;
                    end
                    if (r_idx == EW'(ENTRIES - 1)) begin
                        r_state <= S_ACT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_ACT: begin
                    r_out.status <= pfrl_pkg::ST_OK;
                    r_out.denied <= r_hit ? r_den[r_hit_idx] : 1'b0;
                    r_out.fail_count <= r_hit ? 5'(r_count[r_hit_idx]) : 5'd0;
                    if (r_in.op == pfrl_pkg::OP_FAIL) begin
                        if (!act_ok) begin
                            r_out.status <= pfrl_pkg::ST_TABLE_FULL;
                        end else if (r_count[act_e] >= CW'(FAILS_PER_ENTRY)) begin
                            r_out.status <= pfrl_pkg::ST_FIFO_FULL;
                        end else begin
                            r_valid[act_e] <= 1'b1;
                            r_key[act_e]   <= r_in.peer_key;
                            r_count[act_e] <= n_cnt;
                            if (!r_hit) begin
                                r_head[act_e] <= '0;
                            end
                            r_out.fail_count <= 5'(n_cnt);
                            if ((r_hit && r_den[act_e]) ) begin
                                r_out.denied <= 1'b1;
                            end else if (6'(n_cnt) >= 6'(r_limit)) begin
                                r_den[act_e]  <= 1'b1;
                                r_dend[act_e] <= r_in.now_ms + r_protect;
                                r_out.denied  <= 1'b1;
                            end else begin
                                r_den[act_e]  <= 1'b0;
                                r_out.denied  <= 1'b0;
                            end
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `PPFRL_ASSERT_NEXT(a_accept_starts_sweep, i_clk, i_rst_n,
        i_valid && o_ready, !o_ready && !o_valid, "accepted item must start sweep")
    `PPFRL_ASSERT_ALWAYS(a_no_overlap, i_clk, i_rst_n,
        !(o_valid && o_ready), "result and accept overlap")
    `PPFRL_ASSERT_NEXT(a_hold_result, i_clk, i_rst_n,
        o_valid && !i_ready, o_valid && $stable(o_data), "result dropped while stalled")
endmodule

FILE: rtl/core/pfrl_expiry_mem.sv
// ----------------------------------------------------------------------------
// pfrl_expiry_mem
// Failure expiry store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pfrl_expiry_mem #(
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [31:0]              i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [31:0]              o_rdata
);
    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
